@@ src/bfs_pkg.sv @@
// Package for the byte-stream field serializer.
// Holds the word types, opcode codes, state codes and sizing constants.
// No dependencies.
package bfs_pkg;

  localparam int unsigned PosW     = 48;  // width of the running byte count
  localparam int unsigned MaxAlign = 64;  // largest honored alignment
  localparam int unsigned CntW     = 7;   // holds up to MaxAlign - 1 and PosW - 1
  localparam int unsigned IdxW     = $clog2(PosW);

  localparam logic [2:0] OpByte   = 3'd0;
  localparam logic [2:0] OpVarint = 3'd1;
  localparam logic [2:0] OpZigzag = 3'd2;
  localparam logic [2:0] OpLe16   = 3'd3;
  localparam logic [2:0] OpLe32   = 3'd4;
  localparam logic [2:0] OpLe64   = 3'd5;
  localparam logic [2:0] OpAlign  = 3'd6;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] value;
    logic [6:0]  alignment;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_word_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StEmit = 4'b0010,
    StDiv  = 4'b0100,
    StPad  = 4'b1000
  } state_e;

endpackage

@@ src/bytecode_field_serializer.sv @@
// Byte-stream field serializer: raw byte, LEB128 and zigzag varints,
// little-endian words and alignment padding. Uses bfs_pkg.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): one field per word.
// A word is taken when in_valid_i is high and in_stall_o is low; in_stall_o
// stays high while an item is being worked on.
// Output channel (out_valid_o / out_stall_i / out_word_o): one serialized
// byte per word, last set on the final byte of each item. The output register
// holds a byte while out_stall_i is high; the emit and pad states wait with it.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): pad byte value,
// always ready.
// Timing: encoding items emit one byte per cycle while out_stall_i is low
// (1 for a raw byte, up to 10 for a varint, 8 for le64). An align item first
// runs a bit-serial remainder of the 48-bit byte count against the alignment,
// stepping through one shared subtract/compare unit, then emits its pad
// bytes one per cycle while out_stall_i is low. The first output byte is
// registered from the emit state, which the accept moves into.
// Reset clears the byte count, the pad byte, the state and the output valid.
module bytecode_field_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bfs_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bfs_pkg::out_word_t  out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);

  bfs_pkg::state_e               state_q, state_d;
  logic [63:0]                   shift_q, shift_d;
  logic                          is_var_q, is_var_d;
  logic [bfs_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [6:0]                    rem_q, rem_d;
  logic [6:0]                    align_q, align_d;
  logic [bfs_pkg::PosW-1:0]      pos_q, pos_d;
  logic [7:0]                    pad_q;
  logic                          out_valid_q, out_valid_d;
  bfs_pkg::out_word_t            out_q, out_d;

  logic        slot_free;
  logic        accept;
  logic [63:0] rest;
  logic [6:0]  align_clip;
  logic [6:0]  trial;

  assign in_stall_o  = (state_q != bfs_pkg::StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign rest       = shift_q >> 7;
  assign align_clip = (in_word_i.alignment > 7'(bfs_pkg::MaxAlign))
                      ? 7'(bfs_pkg::MaxAlign) : in_word_i.alignment;
  // shared remainder step: bring in the next count bit, subtract if it fits
  assign trial      = {rem_q[5:0], pos_q[cnt_q[bfs_pkg::IdxW-1:0]]};

  always_comb begin
    state_d     = state_q;
    shift_d     = shift_q;
    is_var_d    = is_var_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    align_d     = align_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      bfs_pkg::StIdle: begin
        if (accept) begin
          shift_d  = in_word_i.value;
          is_var_d = 1'b0;
          case (in_word_i.opcode)
            bfs_pkg::OpByte: begin
              cnt_d   = bfs_pkg::CntW'(1);
              state_d = bfs_pkg::StEmit;
            end
            bfs_pkg::OpVarint: begin
              is_var_d = 1'b1;
              state_d  = bfs_pkg::StEmit;
            end
            bfs_pkg::OpZigzag: begin
              shift_d  = {in_word_i.value[62:0], 1'b0} ^ {64{in_word_i.value[63]}};
              is_var_d = 1'b1;
              state_d  = bfs_pkg::StEmit;
            end
            bfs_pkg::OpLe16: begin
              cnt_d   = bfs_pkg::CntW'(2);
              state_d = bfs_pkg::StEmit;
            end
            bfs_pkg::OpLe32: begin
              cnt_d   = bfs_pkg::CntW'(4);
              state_d = bfs_pkg::StEmit;
            end
            bfs_pkg::OpLe64: begin
              cnt_d   = bfs_pkg::CntW'(8);
              state_d = bfs_pkg::StEmit;
            end
            bfs_pkg::OpAlign: begin
              // alignment below two needs nothing
              if (align_clip >= 7'd2) begin
                align_d = align_clip;
                rem_d   = '0;
                cnt_d   = bfs_pkg::CntW'(bfs_pkg::PosW - 1);
                state_d = bfs_pkg::StDiv;
              end
            end
            default: ;
          endcase
        end
      end

      bfs_pkg::StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          pos_d       = pos_q + bfs_pkg::PosW'(1);
          if (is_var_q) begin
            out_d.out_byte = {(rest != '0), shift_q[6:0]};
            out_d.last     = (rest == '0);
            shift_d        = rest;
          end else begin
            out_d.out_byte = shift_q[7:0];
            out_d.last     = (cnt_q == bfs_pkg::CntW'(1));
            shift_d        = shift_q >> 8;
            cnt_d          = cnt_q - bfs_pkg::CntW'(1);
          end
          if (out_d.last) begin
            state_d = bfs_pkg::StIdle;
          end
        end
      end

      bfs_pkg::StDiv: begin
        rem_d = (trial >= align_q) ? trial - align_q : trial;
        if (cnt_q == '0) begin
          // pad = (align - rem) % align
          if (rem_d == '0) begin
            state_d = bfs_pkg::StIdle;
          end else begin
            cnt_d   = bfs_pkg::CntW'(align_q - rem_d);
            state_d = bfs_pkg::StPad;
          end
        end else begin
          cnt_d = cnt_q - bfs_pkg::CntW'(1);
        end
      end

      bfs_pkg::StPad: begin
        if (slot_free) begin
          out_valid_d    = 1'b1;
          out_d.out_byte = pad_q;
          out_d.last     = (cnt_q == bfs_pkg::CntW'(1));
          pos_d          = pos_q + bfs_pkg::PosW'(1);
          cnt_d          = cnt_q - bfs_pkg::CntW'(1);
          if (out_d.last) begin
            state_d = bfs_pkg::StIdle;
          end
        end
      end

      default: begin
        state_d = bfs_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfs_pkg::StIdle;
      pos_q       <= '0;
      pad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pad_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q  <= shift_d;
    is_var_q <= is_var_d;
    cnt_q    <= cnt_d;
    rem_q    <= rem_d;
    align_q  <= align_d;
    out_q    <= out_d;
  end

endmodule
